### rtl/line_sensor_min_max_normalizer_unit_assert.svh
// ----------------------------------------------------------------------------
// line sensor normaliser assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_MIN_MAX_NORMALIZER_UNIT_ASSERT_SVH
`define LINE_SENSOR_MIN_MAX_NORMALIZER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LSMN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define LSMN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/lsmn_pkg.sv
// ----------------------------------------------------------------------------
// lsmn_pkg
// shared types and constants of the line sensor min/max normaliser
// ----------------------------------------------------------------------------
`default_nettype none

package lsmn_pkg;

    // default geometry
    localparam int CHANNELS_DEF    = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    // fixed field widths
    localparam int TURN_BITS  = 10;
    localparam int LEVEL_BITS = 16;

    // percent scale and the bits it adds to a product
    localparam int PERCENT      = 100;
    localparam int PERCENT_BITS = 7;

    // warm-up register reset
    localparam logic [TURN_BITS-1:0] WARMUP_RESET = 10'd20;

    // frame kinds carried on tuser
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_READ      = 1'b1;

    // saturation limits
    localparam logic [31:0]           SAT_POS_LIMIT = 32'd32767;
    localparam logic [31:0]           SAT_NEG_LIMIT = 32'd32768;
    localparam logic [LEVEL_BITS-1:0] LEVEL_POS_MAX = 16'h7FFF;
    localparam logic [LEVEL_BITS-1:0] LEVEL_NEG_MIN = 16'h8000;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO    = 16'h0000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

### rtl/line_sensor_min_max_normalizer_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_min_max_normalizer_unit
// A frame of CHANNELS reflectance samples enters on the slave stream. A
// calibrate frame (tuser 0) whose turn index is above the warm-up register
// widens each channel's running minimum and maximum, one channel per cycle,
// and gives no output word; frames at or below the warm-up count are dropped
// in the accept cycle. A read frame (tuser 1) gives one output word holding
// (sample - min) * 100 / (max - min) per channel, truncated toward zero and
// saturated to 16 bits signed; a channel whose max is not above its min
// gives 0 and sets the fault flag on tuser. All divisions go through one
// shared restoring divider giving one quotient bit per cycle; an empty-span
// channel skips the divider. The input is not ready while a frame is in
// work; a finished word waits in the output register while the next frame
// is taken. The warm-up register may be written at any time the block is
// idle; it is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_min_max_normalizer_unit_assert.svh"

module line_sensor_min_max_normalizer_unit #(
    parameter  int CHANNELS    = lsmn_pkg::CHANNELS_DEF,
    parameter  int SAMPLE_BITS = lsmn_pkg::SAMPLE_BITS_DEF,
    localparam int IN_DATA_W   = ((lsmn_pkg::TURN_BITS + CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = CHANNELS * lsmn_pkg::LEVEL_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // warm-up register write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lsmn_pkg::TURN_BITS-1:0] i_cfg_data,
    // frame in
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // turn_index, sample_left_outer, sample_left, sample_center,
    // sample_right, sample_right_outer, zero pad
    input  wire logic [IN_DATA_W-1:0]           s_axis_tdata,
    // operation
    input  wire logic [0:0]                     s_axis_tuser,
    // levels out
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // level_left_outer, level_left, level_center, level_right,
    // level_right_outer
    output logic [OUT_DATA_W-1:0]               m_axis_tdata,
    // span_fault
    output logic [0:0]                          m_axis_tuser
);
    import lsmn_pkg::*;

    localparam int NUM_W = SAMPLE_BITS + PERCENT_BITS;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    t_state                r_state;
    t_state                n_state;
    logic [CH_W-1:0]       r_chan;
    logic [CH_W-1:0]       n_chan;
    logic [TURN_BITS-1:0]  r_warmup;
    logic [SAMPLE_BITS-1:0] r_samples [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_min     [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_max     [CHANNELS];
    logic [LEVEL_BITS-1:0] r_level   [CHANNELS];
    logic                  r_fault;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_fault;

    logic                   in_accept;
    logic                   in_op;
    logic [TURN_BITS-1:0]   in_turn;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] cur_sample;
    logic [SAMPLE_BITS-1:0] cur_min;
    logic [SAMPLE_BITS-1:0] cur_max;
    logic                   span_empty;
    logic [SAMPLE_BITS:0]   diff;
    logic                   diff_neg;
    logic [SAMPLE_BITS:0]   diff_abs;
    logic [NUM_W-1:0]       div_dividend;
    logic [SAMPLE_BITS-1:0] div_divisor;
    logic                   div_start;
    logic [NUM_W-1:0]       div_quo;
    t_div_status            div_stat;
    logic [31:0]            quo_ext;
    logic [LEVEL_BITS-1:0]  sat_level;

    // handshake and field decode
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser[0];
    assign in_turn       = s_axis_tdata[TURN_BITS-1:0];
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // channel operands
    always_comb begin
        cur_sample   = r_samples[r_chan];
        cur_min      = r_min[r_chan];
        cur_max      = r_max[r_chan];
        span_empty   = (cur_max <= cur_min);
        diff         = {1'b0, cur_sample} - {1'b0, cur_min};
        diff_neg     = diff[SAMPLE_BITS];
        diff_abs     = diff_neg ? ((SAMPLE_BITS + 1)'(0) - diff) : diff;
        div_dividend = NUM_W'(diff_abs[SAMPLE_BITS-1:0]) * NUM_W'(PERCENT);
        div_divisor  = cur_max - cur_min;
        div_start    = (r_state == ST_PREP) && !span_empty;
    end

    // saturate the quotient magnitude with its sign
    always_comb begin
        quo_ext = 32'(div_quo);
        if (!r_neg) begin
            sat_level = (quo_ext > SAT_POS_LIMIT) ? LEVEL_POS_MAX : quo_ext[LEVEL_BITS-1:0];
        end else begin
            sat_level = (quo_ext > SAT_NEG_LIMIT) ? LEVEL_NEG_MIN
                                                  : LEVEL_BITS'(32'd0 - quo_ext);
        end
    end

    // shared divider
    lsmn_div #(
        .DIVIDEND_W (NUM_W),
        .DIVISOR_W  (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_status   (div_stat)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        case (r_state)
            ST_IDLE: begin
                n_chan = '0;
                if (in_accept) begin
                    if (in_op == OP_READ) begin
                        n_state = ST_PREP;
                    end else if (in_turn > r_warmup) begin
                        n_state = ST_CAL;
                    end
                end
            end
            ST_CAL: begin
                n_chan = r_chan + CH_W'(1);
                if (r_chan == LAST_CH) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PREP: begin
                if (!span_empty) begin
                    n_state = ST_DIV;
                end else if (r_chan == LAST_CH) begin
                    n_state = ST_OUT;
                end else begin
                    n_chan = r_chan + CH_W'(1);
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (r_chan == LAST_CH) begin
                        n_state = ST_OUT;
                    end else begin
                        n_chan  = r_chan + CH_W'(1);
                        n_state = ST_PREP;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control, calibration span and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chan      <= '0;
            r_warmup    <= WARMUP_RESET;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_min[c] <= '1;
                r_max[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            if (i_cfg_valid) begin
                r_warmup <= i_cfg_data;
            end
            if (in_accept) begin
                r_fault <= 1'b0;
            end else if ((r_state == ST_PREP) && span_empty) begin
                r_fault <= 1'b1;
            end
            // widen the span of the current channel
            if (r_state == ST_CAL) begin
                if (cur_sample > cur_max) begin
                    r_max[r_chan] <= cur_sample;
                end
                if (cur_sample < cur_min) begin
                    r_min[r_chan] <= cur_sample;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word capture, per-channel levels and output word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_samples[c] <= s_axis_tdata[TURN_BITS + c * SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        if (r_state == ST_PREP) begin
            r_neg <= diff_neg;
            if (span_empty) begin
                r_level[r_chan] <= LEVEL_ZERO;
            end
        end
        if ((r_state == ST_DIV) && div_stat.done) begin
            r_level[r_chan] <= sat_level;
        end
        if (out_load) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out_data[c * LEVEL_BITS +: LEVEL_BITS] <= r_level[c];
            end
            r_out_fault <= r_fault;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_fault;

    // checks
    `LSMN_ASSERT_IMP(a_div_done_in_div, div_stat.done, r_state == ST_DIV)
    `LSMN_ASSERT_IMP(a_chan_in_range, r_state != ST_IDLE, r_chan <= LAST_CH)
    `LSMN_ASSERT_IMP(a_out_from_seq, $rose(r_out_valid), $past(r_state) == ST_OUT)
    `LSMN_ASSERT_NXT(a_cal_div_idle, r_state == ST_CAL, !div_stat.busy)

endmodule

`default_nettype wire

### rtl/lsmn_div.sv
// ----------------------------------------------------------------------------
// lsmn_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_sensor_min_max_normalizer_unit_assert.svh"

module lsmn_div #(
    parameter int DIVIDEND_W = lsmn_pkg::SAMPLE_BITS_DEF + lsmn_pkg::PERCENT_BITS,
    parameter int DIVISOR_W  = lsmn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output lsmn_pkg::t_div_status      o_status
);
    import lsmn_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // one trial subtraction per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end

    // control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    // checks
    `LSMN_ASSERT_IMP(a_no_start_when_busy, i_start, !r_busy)
    `LSMN_ASSERT_IMP(a_done_after_busy, r_done, $past(r_busy) && !r_busy)
    `LSMN_ASSERT_NXT(a_busy_after_start, i_start, r_busy)

endmodule

`default_nettype wire
